[rtl/core/c3ca_pkg.sv]
// ----------------------------------------------------------------------------
// c3ca_pkg
// Shared types and constants for the 3x3 channel-accumulating convolver.
// ----------------------------------------------------------------------------
package c3ca_pkg;

  localparam int MAX_SIZE    = 224;
  localparam int PAD_MAX     = MAX_SIZE + 2;
  localparam int STORE_DEPTH = PAD_MAX * PAD_MAX;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int LINE_AW     = $clog2(PAD_MAX);
  localparam int CNT_W       = $clog2(PAD_MAX + 1);
  localparam int FS_W        = 8;
  localparam int ADDR_W      = 16;
  localparam int SAMPLE_W    = 16;
  localparam int WIDX_W      = 4;
  localparam int ACC_W       = 48;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int SUM_W       = PROD_W + 4;
  localparam int TAPS        = 9;
  localparam int Q_DEPTH     = 8;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int FRONT_STAGES = 3;

  typedef enum logic [1:0] {
    OP_WEIGHT  = 2'd0,
    OP_PIXEL   = 2'd1,
    OP_READ    = 2'd2,
    OP_PRELOAD = 2'd3
  } opcode_t;

  // OP_PIXEL in a command means: add data to the entry.
  typedef struct packed {
    opcode_t                  kind;
    logic [ADDR_W-1:0]        addr;
    logic signed [ACC_W-1:0]  data;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

[rtl/core/c3ca_queue.sv]
// ----------------------------------------------------------------------------
// c3ca_queue
// Short command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module c3ca_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  c3ca_pkg::cmd_t         push_cmd,
  input  logic                   pop,
  output logic                   pop_valid,
  output c3ca_pkg::cmd_t         pop_cmd,
  output logic [c3ca_pkg::Q_AW:0] count
);
  import c3ca_pkg::*;

  cmd_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic            do_pop;

  assign pop_valid = (count != '0);
  assign pop_cmd   = slots[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (Q_AW+1)'(push) - (Q_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/core/c3ca_front.sv]
// ----------------------------------------------------------------------------
// c3ca_front
// Decodes words, keeps weights, line buffers and the 3x3 window, and forms
// window sums; emits store commands in order.
// ----------------------------------------------------------------------------
module c3ca_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [c3ca_pkg::FS_W-1:0]         frame_size,
  input  c3ca_pkg::back_status_t            back_status,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  c3ca_pkg::opcode_t                 opcode,
  input  logic                              frame_start,
  input  logic [c3ca_pkg::WIDX_W-1:0]       weight_index,
  input  logic signed [c3ca_pkg::SAMPLE_W-1:0] sample,
  input  logic [c3ca_pkg::ADDR_W-1:0]       entry_address,
  input  logic signed [c3ca_pkg::ACC_W-1:0] preload_value,
  input  logic [c3ca_pkg::Q_AW:0]           q_count,
  output logic                              push,
  output c3ca_pkg::cmd_t                    push_cmd
);
  import c3ca_pkg::*;

  logic signed [SAMPLE_W-1:0] weights [TAPS];
  logic signed [SAMPLE_W-1:0] line0 [PAD_MAX];
  logic signed [SAMPLE_W-1:0] line1 [PAD_MAX];
  logic signed [SAMPLE_W-1:0] win [3][3];
  logic signed [SAMPLE_W-1:0] win_next [3][3];
  logic [CNT_W-1:0]   row;
  logic [CNT_W-1:0]   col;
  logic [CNT_W-1:0]   r0;
  logic [CNT_W-1:0]   c0;
  logic [CNT_W-1:0]   pad_w;
  logic [LINE_AW-1:0] c_idx;
  logic               accept;
  logic               is_pix;
  logic               inframe;
  logic [ADDR_W-1:0]  acc_addr;
  logic               line_clr;
  logic [LINE_AW-1:0] clr_idx;

  logic                       s1_win;
  logic                       s1_acc;
  logic                       s1_cmd;
  logic                       s1_par;
  opcode_t                    s1_kind;
  logic [ADDR_W-1:0]          s1_addr;
  logic signed [ACC_W-1:0]    s1_data;
  logic signed [SAMPLE_W-1:0] s1_pix;
  logic signed [SAMPLE_W-1:0] lr0;
  logic signed [SAMPLE_W-1:0] lr1;
  logic signed [SAMPLE_W-1:0] col_top;
  logic signed [SAMPLE_W-1:0] col_mid;

  logic                       s2_valid;
  opcode_t                    s2_kind;
  logic [ADDR_W-1:0]          s2_addr;
  logic signed [ACC_W-1:0]    s2_data;
  logic signed [PROD_W-1:0]   s2_prod [TAPS];
  logic signed [SUM_W-1:0]    sum;

  always_comb begin
    if (frame_size == '0) begin
      pad_w = CNT_W'(3);
    end else if (int'(frame_size) > MAX_SIZE) begin
      pad_w = CNT_W'(MAX_SIZE + 2);
    end else begin
      pad_w = CNT_W'(frame_size) + CNT_W'(2);
    end
  end

  assign in_ready = !back_status.clearing && !line_clr &&
                    (int'(q_count) <= Q_DEPTH - FRONT_STAGES - 1);
  assign accept   = in_valid && in_ready;
  assign is_pix   = (opcode == OP_PIXEL);
  assign r0       = frame_start ? '0 : row;
  assign c0       = frame_start ? '0 : col;
  assign inframe  = (r0 < pad_w) && (c0 < pad_w);
  assign c_idx    = c0[LINE_AW-1:0];
  assign acc_addr = ADDR_W'(r0 - 1'b1) * ADDR_W'(pad_w) + ADDR_W'(c0 - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      for (int k = 0; k < TAPS; k++) begin
        weights[k] <= '0;
      end
    end else if (accept) begin
      if (opcode == OP_WEIGHT && int'(weight_index) < TAPS) begin
        weights[weight_index] <= sample;
      end
      if (is_pix) begin
        if (inframe) begin
          if (c0 + 1'b1 >= pad_w) begin
            col <= '0;
            row <= r0 + 1'b1;
          end else begin
            col <= c0 + 1'b1;
            row <= r0;
          end
        end else begin
          col <= c0;
          row <= r0;
        end
      end
    end
  end

  // zero the line buffers after reset, one column per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      line_clr <= 1'b1;
      clr_idx  <= '0;
    end else if (line_clr) begin
      if (int'(clr_idx) == PAD_MAX - 1) begin
        line_clr <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // line buffers: old column value out, new pixel in
  always_ff @(posedge clk) begin
    if (line_clr) begin
      line0[clr_idx] <= '0;
      line1[clr_idx] <= '0;
    end else if (accept && is_pix && inframe) begin
      lr0 <= line0[c_idx];
      lr1 <= line1[c_idx];
      if (r0[0]) begin
        line1[c_idx] <= sample;
      end else begin
        line0[c_idx] <= sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_win <= 1'b0;
      s1_acc <= 1'b0;
      s1_cmd <= 1'b0;
    end else begin
      s1_win <= accept && is_pix && inframe;
      s1_acc <= accept && is_pix && inframe && (r0 >= CNT_W'(2)) && (c0 >= CNT_W'(2));
      s1_cmd <= accept && (opcode == OP_READ || opcode == OP_PRELOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind <= opcode;
      s1_addr <= is_pix ? acc_addr : entry_address;
      s1_data <= preload_value;
      s1_pix  <= sample;
      s1_par  <= r0[0];
    end
  end

  assign col_top = s1_par ? lr1 : lr0;
  assign col_mid = s1_par ? lr0 : lr1;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      win_next[a][0] = win[a][1];
      win_next[a][1] = win[a][2];
    end
    win_next[0][2] = col_top;
    win_next[1][2] = col_mid;
    win_next[2][2] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (s1_win) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_acc || s1_cmd;
    end
  end

  always_ff @(posedge clk) begin
    s2_kind <= s1_kind;
    s2_addr <= s1_addr;
    s2_data <= s1_data;
    if (s1_acc) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          s2_prod[a*3+b] <= win_next[a][b] * weights[a*3+b];
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + SUM_W'(s2_prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    push_cmd.kind <= s2_kind;
    push_cmd.addr <= s2_addr;
    if (s2_kind == OP_PIXEL) begin
      push_cmd.data <= {{(ACC_W-SUM_W){sum[SUM_W-1]}}, sum};
    end else begin
      push_cmd.data <= s2_data;
    end
  end

endmodule

[rtl/core/c3ca_back.sv]
// ----------------------------------------------------------------------------
// c3ca_back
// Accumulator store: read-modify-write with saturation, preload, read-out,
// and the clearing sweep after reset.
// ----------------------------------------------------------------------------
module c3ca_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  c3ca_pkg::cmd_t         q_cmd,
  output logic                   q_pop,
  output c3ca_pkg::back_status_t status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [c3ca_pkg::ACC_W-1:0] out_value,
  output logic [c3ca_pkg::ADDR_W-1:0]       out_addr
);
  import c3ca_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [ACC_W-1:0] store [STORE_DEPTH];
  logic                    clearing;
  logic [STORE_AW-1:0]     clr_addr;

  logic                    b1_valid;
  cmd_t                    b1;
  logic signed [ACC_W-1:0] rdata;
  logic                    fwd_hit;
  logic signed [ACC_W-1:0] fwd_val;
  logic signed [ACC_W-1:0] old_val;
  logic signed [ACC_W:0]   ext_sum;
  logic signed [ACC_W-1:0] sat_val;
  logic signed [ACC_W-1:0] wval;
  logic                    in_range;
  logic                    hold;
  logic                    adv;
  logic                    done;
  logic                    we;

  assign status.clearing = clearing;
  assign hold     = b1_valid && (b1.kind == OP_READ) && out_valid && !out_ready;
  assign adv      = !hold;
  assign done     = b1_valid && adv;
  assign q_pop    = q_valid && adv && !clearing;
  assign in_range = (int'(b1.addr) < STORE_DEPTH);
  assign old_val  = fwd_hit ? fwd_val : rdata;
  assign ext_sum  = {old_val[ACC_W-1], old_val} + {b1.data[ACC_W-1], b1.data};

  always_comb begin
    if (ext_sum[ACC_W] != ext_sum[ACC_W-1]) begin
      sat_val = ext_sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_val = ext_sum[ACC_W-1:0];
    end
    wval = (b1.kind == OP_PIXEL) ? sat_val : b1.data;
    we   = done && ((b1.kind == OP_PIXEL) || (b1.kind == OP_PRELOAD && in_range));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (int'(clr_addr) == STORE_DEPTH - 1) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      store[clr_addr] <= '0;
    end else if (we) begin
      store[b1.addr[STORE_AW-1:0]] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rdata <= store[q_cmd.addr[STORE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (adv) begin
      b1_valid <= q_pop;
      if (q_pop) begin
        fwd_hit <= we && (b1.addr == q_cmd.addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1      <= q_cmd;
      fwd_val <= wval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && b1.kind == OP_READ) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && b1.kind == OP_READ) begin
      out_value <= in_range ? old_val : '0;
      out_addr  <= b1.addr;
    end
  end

endmodule

[rtl/core/conv3x3_channel_accumulate.sv]
// ----------------------------------------------------------------------------
// conv3x3_channel_accumulate
// 3x3 convolution over padded channel frames, summed into an output store.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle for every opcode while results are taken.
// Read path: a read word passes the front registers s1, s2 and push, the
//   queue, the store read and the output register before its result shows.
// Reset: rst clears control, weights and counters, then clearing sweeps zero
//   the store (all STORE_DEPTH = 51076 entries) and the line buffers; s_tready
//   stays low meanwhile.
module conv3x3_channel_accumulate (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,      // frame_size
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,       // weight_index[3:0], sample[19:4],
                                     // entry_address[35:20], preload_value[83:36]
  input  logic [2:0]  s_tuser,       // opcode[1:0], frame_start[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata        // read_value[47:0], read_address[63:48]
);
  import c3ca_pkg::*;

  logic [FS_W-1:0]         frame_size;
  back_status_t            back_status;
  logic [Q_AW:0]           q_count;
  logic                    push;
  cmd_t                    push_cmd;
  logic                    q_valid;
  cmd_t                    q_cmd;
  logic                    q_pop;
  logic signed [ACC_W-1:0] read_value;
  logic [ADDR_W-1:0]       read_address;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_size <= FS_W'(224);
    end else if (cfg_valid) begin
      frame_size <= cfg_data;
    end
  end

  c3ca_front u_front (
    .clk           (clk),
    .rst           (rst),
    .frame_size    (frame_size),
    .back_status   (back_status),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .opcode        (opcode_t'(s_tuser[1:0])),
    .frame_start   (s_tuser[2]),
    .weight_index  (s_tdata[3:0]),
    .sample        (s_tdata[19:4]),
    .entry_address (s_tdata[35:20]),
    .preload_value (s_tdata[83:36]),
    .q_count       (q_count),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  c3ca_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd),
    .count     (q_count)
  );

  c3ca_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .status    (back_status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (read_value),
    .out_addr  (read_address)
  );

  assign m_tdata = {read_address, read_value};

endmodule

[rtl/core/c3ca_checker.sv]
// ----------------------------------------------------------------------------
// c3ca_checker
// Port-level checks for conv3x3_channel_accumulate.
// ----------------------------------------------------------------------------
module c3ca_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_ready,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);
  import c3ca_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready)
    else $error("outputs active right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (int'(m_tdata[63:48]) >= STORE_DEPTH) |-> (m_tdata[47:0] == '0))
    else $error("read beyond store returned nonzero");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind conv3x3_channel_accumulate c3ca_checker u_c3ca_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg_ready),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);

[dv/tb_conv3x3_channel_accumulate.sv]
// ----------------------------------------------------------------------------
// tb_conv3x3_channel_accumulate
// Self-checking bench for the 3x3 channel-accumulating convolver. Drives
// weight loads, pixel frames, preloads and reads on the input stream and
// compares each read word against a local model of the store and line buffer.
// ----------------------------------------------------------------------------
module tb_conv3x3_channel_accumulate;
  timeunit 1ns;
  timeprecision 1ps;
  import c3ca_pkg::*;

  typedef struct packed {
    opcode_t            op;
    logic               fstart;
    logic [3:0]         widx;
    logic signed [15:0] smp;
    logic [15:0]        addr;
    logic signed [47:0] pval;
  } word_t;

  typedef struct packed {
    logic signed [47:0] val;
    logic [15:0]        addr;
  } rd_t;

  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [7:0]  cfg_data;
  logic        s_tvalid, s_tready;
  logic [87:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid, m_tready;
  logic [63:0] m_tdata;

  conv3x3_channel_accumulate dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  localparam logic signed [47:0] ACC_HI = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] ACC_LO = {1'b1, {47{1'b0}}};

  // local model state
  logic [7:0]          fsize;
  logic signed [15:0]  wts [TAPS];
  logic signed [15:0]  lines [2*PAD_MAX];
  logic signed [47:0]  acc_mem [STORE_DEPTH];
  logic signed [15:0]  win [3][3];
  int unsigned         row_c, col_c;

  word_t pending[$];
  rd_t   reads_due[$];
  int    errors, reads_seen, pixels_sent, cycles;
  bit    hold;

  function automatic int unsigned pad_width();
    int unsigned n;
    n = fsize;
    if (n < 1) n = 1;
    if (n > MAX_SIZE) n = MAX_SIZE;
    return n + 2;
  endfunction

  task automatic conv_pixel(input logic fs, input logic signed [15:0] px);
    int unsigned w, r, c, ad;
    longint sum, acc;
    w = pad_width();
    if (fs) begin
      row_c = 0;
      col_c = 0;
    end
    r = row_c;
    c = col_c;
    if (r >= w || c >= w) return;
    for (int a = 0; a < 3; a++) begin
      win[a][0] = win[a][1];
      win[a][1] = win[a][2];
    end
    win[0][2] = lines[(r & 1) * PAD_MAX + c];
    win[1][2] = lines[((r + 1) & 1) * PAD_MAX + c];
    win[2][2] = px;
    lines[(r & 1) * PAD_MAX + c] = px;
    if (r >= 2 && c >= 2) begin
      sum = 0;
      ad = (r - 1) * w + (c - 1);
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++)
          sum += longint'(win[a][b]) * longint'(wts[a*3+b]);
      acc = longint'(acc_mem[ad]) + sum;
      if (acc > longint'(ACC_HI)) acc = ACC_HI;
      if (acc < longint'(ACC_LO)) acc = ACC_LO;
      acc_mem[ad] = acc[47:0];
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    row_c = r;
    col_c = c;
  endtask

  task automatic predict_word(input word_t x);
    rd_t e;
    case (x.op)
      OP_WEIGHT: if (x.widx < TAPS) wts[x.widx] = x.smp;
      OP_PIXEL: conv_pixel(x.fstart, x.smp);
      OP_READ: begin
        e.addr = x.addr;
        e.val = (x.addr < STORE_DEPTH) ? acc_mem[x.addr] : '0;
        reads_due.push_back(e);
      end
      default: if (x.addr < STORE_DEPTH) acc_mem[x.addr] = x.pval;
    endcase
  endtask

  function automatic word_t mk(opcode_t op, logic fs, logic [3:0] wi,
                               logic [15:0] s, logic [15:0] ad, logic [47:0] pv);
    word_t x;
    x.op = op; x.fstart = fs; x.widx = wi; x.smp = s; x.addr = ad; x.pval = pv;
    return x;
  endfunction

  function automatic logic [47:0] rnd48();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [15:0] rnd_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return $urandom_range(0, 15) - 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver
  int s_gap;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) predict_word(pending.pop_front());
      if (s_gap > 0 || hold || pending.size() == 0 ||
          (s_tvalid && pending.size() == 1 && 0)) begin
        s_tvalid <= 1'b0;
        if (s_gap > 0) s_gap <= s_gap - 1;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, pending[0].pval, pending[0].addr, pending[0].smp,
                    pending[0].widx};
        s_tuser <= {pending[0].fstart, pending[0].op};
        s_gap <= gap_len();
      end
    end
  end

  // monitor
  int m_gap;
  always @(posedge clk) begin
    rd_t e;
    if (rst) begin
      m_tready <= 1'b0;
      m_gap <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        reads_seen++;
        if (reads_due.size() == 0) begin
          $display("%0t: unexpected read word, actual addr %0d value %0d", $time,
                   m_tdata[63:48], $signed(m_tdata[47:0]));
          errors++;
        end else begin
          e = reads_due.pop_front();
          if (m_tdata[63:48] !== e.addr) begin
            $display("%0t: read_address expected %0d actual %0d", $time,
                     e.addr, m_tdata[63:48]);
            errors++;
          end
          if (m_tdata[47:0] !== e.val) begin
            $display("%0t: read_value @%0d expected %0d actual %0d", $time,
                     e.addr, e.val, $signed(m_tdata[47:0]));
            errors++;
          end
        end
      end
      if (m_gap > 0) begin
        m_tready <= 1'b0;
        m_gap <= m_gap - 1;
      end else begin
        m_tready <= 1'b1;
        m_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 1500000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic drain();
    while (pending.size() != 0 || s_tvalid || reads_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_size(input logic [7:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fsize = v;
  endtask

  // one channel: weights, full frame of pixels, a few reads
  task automatic queue_channel(input int n);
    int w;
    w = n + 2;
    for (int t = 0; t < TAPS; t++) pending.push_back(mk(OP_WEIGHT, 0, t, rnd_sample(), 0, 0));
    for (int p = 0; p < w * w; p++) begin
      pending.push_back(mk(OP_PIXEL, p == 0, 0, rnd_sample(), 0, 0));
      pixels_sent++;
    end
    for (int k = 0; k < 3; k++)
      pending.push_back(mk(OP_READ, 0, 0, 0, $urandom_range(0, w * w - 1), 0));
  endtask

  task automatic queue_noise(input int n);
    int w;
    word_t x;
    w = n + 2;
    x = mk(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 7) == 0,
           $urandom_range(0, 15), rnd_sample(), $urandom_range(0, w * w + 4), rnd48());
    if ($urandom_range(0, 9) == 0) x.addr = $urandom();
    if ($urandom_range(0, 9) == 0) x.addr = STORE_DEPTH - 1;
    pending.push_back(x);
  endtask

  initial begin
    int sizes[6];
    errors = 0; reads_seen = 0; pixels_sent = 0; cycles = 0; hold = 0;
    fsize = 224; row_c = 0; col_c = 0;
    foreach (wts[i]) wts[i] = '0;
    foreach (lines[i]) lines[i] = '0;
    foreach (acc_mem[i]) acc_mem[i] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    rst = 1; cfg_valid = 0; cfg_data = '0;
    s_tdata = '0; s_tuser = '0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: default size, store extremes, saturation, ignored cases
    pending.push_back(mk(OP_READ, 0, 0, 0, 0, 0));
    pending.push_back(mk(OP_PRELOAD, 0, 0, 0, STORE_DEPTH - 1, ACC_HI));
    pending.push_back(mk(OP_READ, 0, 0, 0, STORE_DEPTH - 1, 0));
    pending.push_back(mk(OP_PRELOAD, 0, 0, 0, STORE_DEPTH, 48'h123));
    pending.push_back(mk(OP_READ, 0, 0, 0, 16'hffff, 0));
    pending.push_back(mk(OP_WEIGHT, 0, 4'd15, 16'h7fff, 0, 0));
    pending.push_back(mk(OP_WEIGHT, 0, 4'd9, 16'h7fff, 0, 0));
    for (int t = 0; t < TAPS; t++) pending.push_back(mk(OP_WEIGHT, 0, t, 16'h8000, 0, 0));
    pending.push_back(mk(OP_PRELOAD, 0, 0, 0, 16'd227 * 2, ACC_LO));
    pending.push_back(mk(OP_PRELOAD, 0, 0, 0, 16'd227, ACC_HI));
    drain();

    write_size(8'd0);
    // 3x3 frame of -32768 against -32768 weights drives entry (1,1) high
    pending.push_back(mk(OP_PRELOAD, 0, 0, 0, 16'd4, ACC_HI - 5));
    for (int p = 0; p < 9; p++) pending.push_back(mk(OP_PIXEL, p == 0, 0, 16'h8000, 0, 0));
    pending.push_back(mk(OP_PIXEL, 0, 0, 16'h7fff, 0, 0));
    pending.push_back(mk(OP_READ, 0, 0, 0, 16'd4, 0));
    pending.push_back(mk(OP_PRELOAD, 0, 0, 0, 16'd4, ACC_LO + 3));
    for (int t = 0; t < TAPS; t++) pending.push_back(mk(OP_WEIGHT, 0, t, 16'h7fff, 0, 0));
    for (int p = 0; p < 9; p++) pending.push_back(mk(OP_PIXEL, p == 0, 0, 16'h8000, 0, 0));
    pending.push_back(mk(OP_READ, 0, 0, 0, 16'd4, 0));
    drain();

    sizes = '{1, 2, 3, 255, 5, 1};
    foreach (sizes[s]) begin
      int n;
      write_size(sizes[s][7:0]);
      n = (sizes[s] > MAX_SIZE) ? MAX_SIZE : sizes[s];
      if (n == MAX_SIZE) begin
        // one wide channel, mostly ignored then restarted
        for (int k = 0; k < 40; k++) pending.push_back(mk(OP_PIXEL, k == 0, 0,
                                                    rnd_sample(), 0, 0));
        for (int k = 0; k < 20; k++) queue_noise(3);
      end else begin
        for (int ch = 0; ch < 2; ch++) begin
          queue_channel(n);
          for (int k = 0; k < 8; k++) queue_noise(n);
        end
        for (int k = 0; k < (n + 2) * (n + 2); k += 2)
          pending.push_back(mk(OP_READ, 0, 0, 0, k, 0));
      end
      if (s == 2) begin
        // let every read come back before sending more
        while (pending.size() > 5) @(posedge clk);
        hold = 1;
        while (s_tvalid || reads_due.size() != 0 || pending.size() > 5 && 0)
          @(posedge clk);
        while (s_tvalid) @(posedge clk);
        while (reads_due.size() != 0) @(posedge clk);
        hold = 0;
      end
      drain();
    end

    $display("Covered %0d pixels over sizes 0..255 incl. saturation and bad addresses;",
             pixels_sent);
    $display("%0d read words checked.", reads_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
